/* rtl/open_address_hash_table_assert.svh */
// assertion macros for the open-address hash table
// clocked on clk, disabled while rst is high; no other dependencies
`ifndef OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define OAHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OAHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/oaht_pkg.sv */
// shared constants, codes and controller/datapath interface types
// for the open-address hash table; no dependencies
package oaht_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int SIZE_W    = SLOT_W + 1;
  localparam int KEY_W     = 31;
  localparam int REC_W     = 31;
  localparam int ENTRY_W   = KEY_W + REC_W;
  localparam int STAT_W    = 3;
  localparam int MODE_W    = 2;
  localparam int DIV_STEPS = (KEY_W + 1) / 2;
  localparam int DIV_W     = 2 * DIV_STEPS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(11);

  localparam logic [MODE_W-1:0] MODE_CLEAR  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_INSERT = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_FIND   = MODE_W'(2);

  localparam logic [STAT_W-1:0] ST_DONE      = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_FOUND     = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = STAT_W'(2);
  localparam logic [STAT_W-1:0] ST_DUPLICATE = STAT_W'(3);
  localparam logic [STAT_W-1:0] ST_TOO_MANY  = STAT_W'(4);

  typedef struct packed {
    logic              load;
    logic              div_step;
    logic              seek_home;
    logic              seek_next;
    logic              store;
    logic              wipe;
    logic              finish;
    logic              use_slot;
    logic [STAT_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic key_zero;
    logic hit;
    logic empty;
    logic last_probe;
    logic below_half;
    logic out_free;
  } sts_t;

endpackage

/* rtl/open_address_hash_table.sv */
// top level of the open-address hash table
// depends on oaht_pkg, oaht_ctrl and oaht_dp
//
// One operation is in work at a time; a new beat is taken as soon as the previous result sits
// in the output register. Clear, unused mode and key zero go straight to the finish state.
// Insert and find first run the key mod table_size remainder unit at two bits a cycle, then
// each probe passes a read and a check state for the registered read of the single-port slot
// ram; an insert that stores adds a write state. Clear empties all slots at once through
// per-slot valid flags, so no clearing pass is needed after reset.
module open_address_hash_table
  import oaht_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SIZE_W-1:0]  cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  mode,
  input  logic [KEY_W-1:0]   key,
  input  logic [REC_W-1:0]   record_no,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [SLOT_W-1:0]  position,
  output logic [REC_W-1:0]   found_record_no,
  output logic [SIZE_W-1:0]  probe_count,
  output logic [SIZE_W-1:0]  entry_count
);

  cmd_t cmd;
  sts_t sts;

  oaht_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .mode    (mode),
    .sts     (sts),
    .in_stall(in_stall),
    .cmd     (cmd)
  );

  oaht_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .key            (key),
    .record_no      (record_no),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .position       (position),
    .found_record_no(found_record_no),
    .probe_count    (probe_count),
    .entry_count    (entry_count)
  );

endmodule

/* rtl/oaht_ram.sv */
// generic single-port ram with registered read
// no dependencies
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/oaht_ctrl.sv */
// sequencer for clear, insert and find operations
// depends on oaht_pkg; drives the datapath through cmd_t, reads sts_t
module oaht_ctrl
  import oaht_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] mode,
  input  sts_t              sts,
  output logic              in_stall,
  output cmd_t              cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_HOME = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              is_find, is_find_next;
  logic [STAT_W-1:0] code, code_next;
  logic              use_slot, use_slot_next;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    is_find_next  = is_find;
    code_next     = code;
    use_slot_next = use_slot;
    cmd           = '0;
    cmd.code      = code;
    cmd.use_slot  = use_slot;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          use_slot_next = 1'b0;
          priority if (mode == MODE_CLEAR) begin
            cmd.wipe   = 1'b1;
            code_next  = ST_DONE;
            state_next = S_FIN;
          end else if (mode == MODE_INSERT || mode == MODE_FIND) begin
            is_find_next = (mode == MODE_FIND);
            if (sts.key_zero) begin
              code_next  = ST_NOT_FOUND;
              state_next = S_FIN;
            end else begin
              cnt_next   = '0;
              state_next = S_DIV;
            end
          end else begin
            code_next  = ST_DONE;
            state_next = S_FIN;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_LAST) begin
          state_next = S_HOME;
        end
      end
      S_HOME: begin
        cmd.seek_home = 1'b1;
        state_next    = S_RD;
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        use_slot_next = 1'b1;
        priority if (sts.hit) begin
          code_next  = is_find ? ST_FOUND : ST_DUPLICATE;
          state_next = S_FIN;
        end else if (sts.empty) begin
          if (is_find) begin
            code_next  = ST_NOT_FOUND;
            state_next = S_FIN;
          end else if (sts.below_half) begin
            code_next  = ST_DONE;
            state_next = S_WR;
          end else begin
            code_next  = ST_TOO_MANY;
            state_next = S_FIN;
          end
        end else begin
          cmd.seek_next = 1'b1;
          if (sts.last_probe) begin
            code_next  = is_find ? ST_NOT_FOUND : ST_TOO_MANY;
            state_next = S_FIN;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_WR: begin
        cmd.store  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      is_find  <= 1'b0;
      code     <= ST_DONE;
      use_slot <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      is_find  <= is_find_next;
      code     <= code_next;
      use_slot <= use_slot_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

/* rtl/oaht_dp.sv */
// datapath: size register, remainder unit, probe position, slot store, result beat
// depends on oaht_pkg, oaht_ram and the assertion macro header
`include "open_address_hash_table_assert.svh"

module oaht_dp
  import oaht_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SIZE_W-1:0]  cfg_wr_data,
  input  logic [KEY_W-1:0]   key,
  input  logic [REC_W-1:0]   record_no,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [STAT_W-1:0]  status,
  output logic [SLOT_W-1:0]  position,
  output logic [REC_W-1:0]   found_record_no,
  output logic [SIZE_W-1:0]  probe_count,
  output logic [SIZE_W-1:0]  entry_count
);

  logic [SIZE_W-1:0]  table_size;
  logic [SIZE_W-1:0]  msz;
  logic [KEY_W-1:0]   key_r;
  logic [REC_W-1:0]   rec_r;
  logic [DIV_W-1:0]   kq;
  logic [SLOT_W-1:0]  rem;
  logic [SLOT_W-1:0]  p;
  logic [SIZE_W-1:0]  c;
  logic [SIZE_W-1:0]  count;
  logic [SLOTS-1:0]   slot_vld;
  logic               vld_r;
  logic [ENTRY_W-1:0] rdata;

  logic [SIZE_W-1:0]  t1, r1, t2, r2;
  logic [SIZE_W-1:0]  c1;
  logic [SIZE_W:0]    sum, adv;
  logic               out_free;

  always_comb begin
    if (table_size == '0) begin
      msz = SIZE_W'(1);
    end else if (table_size > SIZE_W'(SLOTS)) begin
      msz = SIZE_W'(SLOTS);
    end else begin
      msz = table_size;
    end
  end

  // two remainder bits per step
  always_comb begin
    t1  = {rem, kq[DIV_W-1]};
    r1  = (t1 >= msz) ? t1 - msz : t1;
    t2  = {r1[SLOT_W-1:0], kq[DIV_W-2]};
    r2  = (t2 >= msz) ? t2 - msz : t2;
    c1  = c + 1'b1;
    sum = {2'b00, p} + {1'b0, c1};
    adv = (sum >= {1'b0, msz}) ? sum - {1'b0, msz} : sum;
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sts            = '0;
    sts.key_zero   = (key == '0);
    sts.hit        = vld_r && (rdata[ENTRY_W-1:REC_W] == key_r);
    sts.empty      = !vld_r;
    sts.last_probe = (c1 >= msz);
    sts.below_half = (c < (msz >> 1));
    sts.out_free   = out_free;
  end

  oaht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (cmd.store),
    .addr (p),
    .wdata({key_r, rec_r}),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
      slot_vld   <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_size <= cfg_wr_data;
      end
      if (cmd.wipe) begin
        slot_vld <= '0;
        count    <= '0;
      end else if (cmd.store) begin
        slot_vld[p] <= 1'b1;
        count       <= count + 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_r <= slot_vld[p];
    if (cmd.load) begin
      key_r <= key;
      rec_r <= record_no;
      kq    <= DIV_W'(key);
      rem   <= '0;
    end else if (cmd.div_step) begin
      kq  <= {kq[DIV_W-3:0], 2'b00};
      rem <= r2[SLOT_W-1:0];
    end
    if (cmd.seek_home) begin
      p <= rem;
      c <= '0;
    end else if (cmd.seek_next) begin
      c <= c1;
      if (!sts.last_probe) begin
        p <= adv[SLOT_W-1:0];
      end
    end
    if (cmd.finish) begin
      status          <= cmd.code;
      position        <= cmd.use_slot ? p : '0;
      probe_count     <= cmd.use_slot ? c : '0;
      found_record_no <= (cmd.use_slot && (cmd.code == ST_FOUND || cmd.code == ST_DUPLICATE))
                         ? rdata[REC_W-1:0] : '0;
      entry_count     <= count;
    end
  end

  `OAHT_ASSERT_IMP(a_probe_in_range, cmd.seek_next || cmd.store, {1'b0, p} < msz, "probe slot outside table")
  `OAHT_ASSERT_NXT(a_store_marks_slot, cmd.store, slot_vld[$past(p)], "stored slot not marked")
  `OAHT_ASSERT_IMP(a_finish_when_free, cmd.finish, out_free, "result beat overwritten")
  `OAHT_ASSERT_IMP(a_count_bound, 1'b1, count <= SIZE_W'(SLOTS), "entry count beyond slots")

endmodule

/* tb/open_address_hash_table_tb.sv */
// self-checking testbench for open_address_hash_table: a directed table, then random phases
// checked beat by beat against a shadow copy of the hash table; needs oaht_pkg and the rtl only
`timescale 1ns / 1ps

module open_address_hash_table_tb
  import oaht_pkg::*;
;

  localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_W'(3);
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 160;
  localparam int PHASES = 14;
  localparam int PHASE_BEATS = 125;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] position;
    logic [REC_W-1:0]  found_record_no;
    logic [SIZE_W-1:0] probe_count;
    logic [SIZE_W-1:0] entry_count;
  } answer_t;

  typedef enum {ROW_OP, ROW_SIZE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [MODE_W-1:0] op;
    logic [KEY_W-1:0]  k;
    logic [REC_W-1:0]  r;
    bit                typed;
    answer_t           fixed;
  } step_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [SIZE_W-1:0]  cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   key;
  logic [REC_W-1:0]   record_no;
  logic               out_valid;
  logic               out_stall;
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  position;
  logic [REC_W-1:0]   found_record_no;
  logic [SIZE_W-1:0]  probe_count;
  logic [SIZE_W-1:0]  entry_count;

  logic [KEY_W-1:0]   shadow_keys [SLOTS];
  logic [REC_W-1:0]   shadow_recs [SLOTS];
  logic [SIZE_W-1:0]  shadow_count = '0;
  logic [SIZE_W-1:0]  shadow_size = SIZE_RESET;

  answer_t pending_answers [$];
  step_t   plan [$];
  int      err_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_asked = 0;
  int      hold_served = 0;
  int      phase_sizes [PHASES] = '{11, 1, 2, 64, 7, 13, 127, 0, 3, 31, 5, 16, 17, 64};

  open_address_hash_table DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .key             (key),
    .record_no       (record_no),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .position        (position),
    .found_record_no (found_record_no),
    .probe_count     (probe_count),
    .entry_count     (entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int live_slots();
    if (shadow_size == '0) return 1;
    if (shadow_size > SLOTS) return SLOTS;
    return int'(shadow_size);
  endfunction

  // applies one operation to the shadow table and returns the answer it gives
  function automatic answer_t table_answer(input logic [MODE_W-1:0] op,
                                           input logic [KEY_W-1:0] k,
                                           input logic [REC_W-1:0] r);
    answer_t a;
    int m;
    int p;
    int c;
    a = '0;
    m = live_slots();
    if (op == MODE_CLEAR) begin
      foreach (shadow_keys[i]) shadow_keys[i] = '0;
      shadow_count = '0;
    end else if (op == MODE_INSERT || op == MODE_FIND) begin
      if (k == '0) begin
        a.status = ST_NOT_FOUND;
      end else begin
        p = int'(longint'(k) % m);
        c = 0;
        while (shadow_keys[p] != '0 && shadow_keys[p] != k && c < m) begin
          c++;
          if (c < m) p = (p + c) % m;
        end
        a.position = SLOT_W'(p);
        a.probe_count = SIZE_W'(c);
        if (shadow_keys[p] == k) begin
          a.status = (op == MODE_INSERT) ? ST_DUPLICATE : ST_FOUND;
          a.found_record_no = shadow_recs[p];
        end else if (op == MODE_FIND) begin
          a.status = ST_NOT_FOUND;
        end else if (c < m / 2) begin
          shadow_keys[p] = k;
          shadow_recs[p] = r;
          shadow_count = shadow_count + 1'b1;
          a.status = ST_DONE;
        end else begin
          a.status = ST_TOO_MANY;
        end
      end
    end
    a.entry_count = shadow_count;
    return a;
  endfunction

  // mostly keys that share a few home slots, some already stored, a few fully random
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] stored;
    int roll;
    roll = $urandom_range(0, 9);
    stored = shadow_keys[$urandom_range(0, SLOTS - 1)];
    if (roll < 4 && stored != '0) return stored;
    if (roll == 9) return KEY_W'($urandom);
    return KEY_W'($urandom_range(0, 3) + live_slots() * $urandom_range(1, 1000000));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [SIZE_W-1:0] size);
    drain_answers();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_size = size;
  endtask

  task automatic offer_beat(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k,
                            input logic [REC_W-1:0] r, input bit typed,
                            input answer_t fixed);
    answer_t a;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    key <= k;
    record_no <= r;
    do @(posedge clk); while (in_stall);
    a = table_answer(op, k, r);
    pending_answers.push_back(typed ? fixed : a);
  endtask

  initial begin : result_sink
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unrequested beat, status", 32'(status), 32'(ST_DONE));
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (position !== want.position)
          report_mismatch("position", 32'(position), 32'(want.position));
        if (found_record_no !== want.found_record_no)
          report_mismatch("found_record_no", 32'(found_record_no), 32'(want.found_record_no));
        if (probe_count !== want.probe_count)
          report_mismatch("probe_count", 32'(probe_count), 32'(want.probe_count));
        if (entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(entry_count), 32'(want.entry_count));
      end
    end
  end

  initial begin : stimulus
    logic [MODE_W-1:0] op;
    logic [KEY_W-1:0]  k;
    logic [REC_W-1:0]  r;
    int roll;
    foreach (shadow_keys[i]) begin
      shadow_keys[i] = '0;
      shadow_recs[i] = '0;
    end
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    mode <= MODE_CLEAR;
    key <= '0;
    record_no <= '0;

    // home slot 5 chain at size 11, key zero, unused mode, out-of-range sizes
    plan.push_back('{ROW_OP, MODE_FIND, 5, 0, 1'b1, '{ST_NOT_FOUND, 5, 0, 0, 0}});
    plan.push_back('{ROW_OP, MODE_INSERT, 5, 100, 1'b1, '{ST_DONE, 5, 0, 0, 1}});
    plan.push_back('{ROW_OP, MODE_INSERT, 5, 7, 1'b1, '{ST_DUPLICATE, 5, 100, 0, 1}});
    plan.push_back('{ROW_OP, MODE_FIND, 5, 0, 1'b1, '{ST_FOUND, 5, 100, 0, 1}});
    plan.push_back('{ROW_OP, MODE_INSERT, 16, 200, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_INSERT, 27, 300, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_INSERT, 0, 5, 1'b1, '{ST_NOT_FOUND, 0, 0, 0, 3}});
    plan.push_back('{ROW_OP, MODE_FIND, 0, 0, 1'b1, '{ST_NOT_FOUND, 0, 0, 0, 3}});
    plan.push_back('{ROW_OP, MODE_UNUSED, '1, '1, 1'b1, '{ST_DONE, 0, 0, 0, 3}});
    plan.push_back('{ROW_OP, MODE_INSERT, '1, '1, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_FIND, '1, 0, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_INSERT, 38, 1, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_INSERT, 49, 2, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_INSERT, 60, 3, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_CLEAR, 0, 0, 1'b1, '{ST_DONE, 0, 0, 0, 0}});
    plan.push_back('{ROW_OP, MODE_FIND, 16, 0, 1'b1, '{ST_NOT_FOUND, 5, 0, 0, 0}});
    plan.push_back('{ROW_SIZE, MODE_CLEAR, 1, 0, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_INSERT, 3, 9, 1'b1, '{ST_TOO_MANY, 0, 0, 0, 0}});
    plan.push_back('{ROW_SIZE, MODE_CLEAR, 0, 0, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_INSERT, 9, 9, 1'b1, '{ST_TOO_MANY, 0, 0, 0, 0}});
    plan.push_back('{ROW_SIZE, MODE_CLEAR, 2, 0, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_INSERT, 2, 1, 1'b1, '{ST_DONE, 0, 0, 0, 1}});
    plan.push_back('{ROW_OP, MODE_INSERT, 3, '1, 1'b1, '{ST_DONE, 1, 0, 0, 2}});
    plan.push_back('{ROW_OP, MODE_FIND, 4, 0, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_INSERT, 6, 8, 1'b0, '0});
    plan.push_back('{ROW_SIZE, MODE_CLEAR, 127, 0, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_INSERT, 127, 55, 1'b0, '0});
    plan.push_back('{ROW_SIZE, MODE_CLEAR, 64, 0, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_FIND, 127, 0, 1'b0, '0});
    plan.push_back('{ROW_OP, MODE_CLEAR, 0, 0, 1'b1, '{ST_DONE, 0, 0, 0, 0}});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SIZE)
        write_table_size(SIZE_W'(plan[i].k));
      else
        offer_beat(plan[i].op, plan[i].k, plan[i].r, plan[i].typed, plan[i].fixed);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_table_size(SIZE_W'(phase_sizes[ph]));
      send_idle_pct = (ph % 4 == 1) ? 85 : (ph % 4 == 3) ? 21 : 0;
      recv_idle_pct = (ph % 4 == 2) ? 85 : (ph % 4 == 3) ? 21 : 0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // long output hold-off while beats keep coming, so the input backs up
        if (ph == 4 && n == 20) hold_asked++;
        roll = $urandom_range(0, 99);
        r = REC_W'($urandom);
        k = random_key();
        op = ($urandom_range(0, 99) < 55) ? MODE_INSERT : MODE_FIND;
        if (roll < 8) k = '0;
        if (roll < 5) begin
          op = MODE_UNUSED;
          k = KEY_W'($urandom);
        end
        if (roll < 3) op = MODE_CLEAR;
        offer_beat(op, k, r, 1'b0, '0);
      end
    end

    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
